[rtl/core/crrs_pkg.sv]
// ----------------------------------------------------------------------------
// crrs_pkg
// Shared types and constants for the cold room relay sequencer.
// ----------------------------------------------------------------------------
package crrs_pkg;

  localparam int NUM_RELAYS = 8;
  localparam int NUM_COMP   = 2;
  localparam int TIME_W     = 32;
  // wide enough to hold any sum or difference of the 12-bit and 10-bit inputs
  localparam int CMP_W      = 14;

  // relay positions in relay_state
  localparam int RLY_C1 = 0;
  localparam int RLY_C2 = 1;
  localparam int RLY_H1 = 2;
  localparam int RLY_H2 = 3;
  localparam int RLY_F1 = 4;
  localparam int RLY_F2 = 5;
  localparam int RLY_T1 = 6;
  localparam int RLY_T2 = 7;

  // heating error thresholds, tenths of a degree
  localparam logic signed [CMP_W-1:0] HEAT_STAGE1_TENTHS = 45;
  localparam logic signed [CMP_W-1:0] HEAT_STAGE2_TENTHS = 80;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic signed [11:0] temperature;
    logic [9:0]        humidity;
    logic [2:0]        comp_one_faults;
    logic [2:0]        comp_two_faults;
    logic [1:0]        heater_faults;
  } item_t;

  typedef struct packed {
    logic signed [11:0] temp_setpoint;
    logic [9:0]         hum_setpoint;
    logic [8:0]         cool_on_delta;
    logic [8:0]         cool_off_delta;
    logic [8:0]         cool_stage2_delta;
    logic [8:0]         hum_deadband;
    logic [9:0]         hum_stage2_delta;
  } cfg_t;

  // per-relay requests for one evaluation; bits 0/1 are the compressors, started by on_req and stopped by off_req
  typedef struct packed {
    logic [NUM_RELAYS-1:0] on_req;
    logic [NUM_RELAYS-1:0] off_req;
  } relay_cmd_t;

endpackage

[rtl/core/crrs_cmd.sv]
// ----------------------------------------------------------------------------
// crrs_cmd
// Turns one evaluation into on/off requests for every relay.
// ----------------------------------------------------------------------------
module crrs_cmd
  import crrs_pkg::*;
(
  input  item_t      item,
  input  cfg_t       cfg,
  output relay_cmd_t cmd
);

  logic signed [CMP_W-1:0] t_w, sp_w, hum_w, hsp_w;
  // deltas zero-extended into signed operands so every compare stays signed
  logic signed [CMP_W-1:0] on_w, off_w, stg2_w, dband_w, hstg2_w;
  logic signed [CMP_W-1:0] heat_err;
  logic need_cool, stop_cool, dehum, humid;
  logic c1_ok, c2_ok, h1_ok, h2_ok;

  always_comb begin
    t_w   = CMP_W'(item.temperature);
    sp_w  = CMP_W'(cfg.temp_setpoint);
    hum_w = CMP_W'(item.humidity);
    hsp_w = CMP_W'(cfg.hum_setpoint);

    on_w    = CMP_W'(cfg.cool_on_delta);
    off_w   = CMP_W'(cfg.cool_off_delta);
    stg2_w  = CMP_W'(cfg.cool_stage2_delta);
    dband_w = CMP_W'(cfg.hum_deadband);
    hstg2_w = CMP_W'(cfg.hum_stage2_delta);

    c1_ok = (item.comp_one_faults == '0);
    c2_ok = (item.comp_two_faults == '0);
    h1_ok = !item.heater_faults[0];
    h2_ok = !item.heater_faults[1];

    need_cool = t_w >= sp_w + on_w;
    stop_cool = t_w <= sp_w - off_w;
    dehum     = hum_w > hsp_w + dband_w;
    humid     = !dehum && (hum_w < hsp_w - dband_w);
    heat_err  = sp_w - t_w;

    cmd = '0;

    // fans always requested on
    cmd.on_req[RLY_F1] = 1'b1;
    cmd.on_req[RLY_F2] = 1'b1;

    if (need_cool) begin
      cmd.off_req[RLY_T1] = 1'b1;
      cmd.off_req[RLY_T2] = 1'b1;
      if (((t_w - sp_w) > stg2_w) && c1_ok && c2_ok) begin
        cmd.on_req[RLY_C1] = 1'b1;
        cmd.on_req[RLY_C2] = 1'b1;
      end else if (c1_ok) begin
        cmd.on_req[RLY_C1] = 1'b1;
      end else if (c2_ok) begin
        cmd.on_req[RLY_C2] = 1'b1;
      end
    end

    // dehumidify: cool and balance with one heater
    if (!need_cool && !stop_cool && dehum) begin
      if (c1_ok) begin
        cmd.on_req[RLY_C1] = 1'b1;
      end else if (c2_ok) begin
        cmd.on_req[RLY_C2] = 1'b1;
      end
      if (h1_ok) begin
        cmd.on_req[RLY_T1]  = 1'b1;
        cmd.off_req[RLY_T2] = 1'b1;
      end else if (h2_ok) begin
        cmd.on_req[RLY_T2]  = 1'b1;
        cmd.off_req[RLY_T1] = 1'b1;
      end
    end

    if (stop_cool) begin
      cmd.off_req[RLY_C1] = 1'b1;
      cmd.off_req[RLY_C2] = 1'b1;
    end

    // staged heating; stage one fails over to the healthy heater
    if (heat_err < HEAT_STAGE1_TENTHS) begin
      cmd.off_req[RLY_T1] = 1'b1;
      cmd.off_req[RLY_T2] = 1'b1;
    end else if (heat_err < HEAT_STAGE2_TENTHS) begin
      if (h1_ok) begin
        cmd.on_req[RLY_T1]  = 1'b1;
        cmd.off_req[RLY_T2] = 1'b1;
      end else if (h2_ok) begin
        cmd.on_req[RLY_T2]  = 1'b1;
        cmd.off_req[RLY_T1] = 1'b1;
      end
    end else if (h1_ok && h2_ok) begin
      cmd.on_req[RLY_T1] = 1'b1;
      cmd.on_req[RLY_T2] = 1'b1;
    end

    if (humid) begin
      cmd.on_req[RLY_H1] = 1'b1;
      if ((hsp_w - hum_w) > hstg2_w) begin
        cmd.on_req[RLY_H2] = 1'b1;
      end else begin
        cmd.off_req[RLY_H2] = 1'b1;
      end
    end else begin
      cmd.off_req[RLY_H1] = 1'b1;
      cmd.off_req[RLY_H2] = 1'b1;
    end
  end

endmodule

[rtl/core/crrs_relay_bank.sv]
// ----------------------------------------------------------------------------
// crrs_relay_bank
// Relay state, change stamps and compressor on/off stamps with dwell guards.
// ----------------------------------------------------------------------------
module crrs_relay_bank
  import crrs_pkg::*;
#(
  parameter int unsigned RELAY_MIN_DWELL_MS   = 30000,
  parameter int unsigned COMP_MIN_ON_TIME_MS  = 180000,
  parameter int unsigned COMP_MIN_OFF_TIME_MS = 180000
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [TIME_W-1:0]     now_ms,
  input  relay_cmd_t            cmd,
  output logic [NUM_RELAYS-1:0] relay_bits,
  output logic [NUM_RELAYS-1:0] relay_bits_nxt
);

  logic [NUM_RELAYS-1:0] relay_bits_r;
  logic [TIME_W-1:0]     chg_stamp_r [NUM_RELAYS];
  logic [TIME_W-1:0]     on_stamp_r  [NUM_COMP];
  logic [TIME_W-1:0]     off_stamp_r [NUM_COMP];

  logic [NUM_RELAYS-1:0] dwell_ok;
  logic [NUM_RELAYS-1:0] change;
  logic [NUM_COMP-1:0]   on_time_ok, off_time_ok;
  logic [NUM_COMP-1:0]   start_take, stop_take;

  // A relay changes at most once per evaluation: after a change its stamp is
  // now, so any reverse request fails the dwell check. Hence for the non-compressor
  // relays the change is simply "dwell ok and some request opposes the current state".
  always_comb begin
    for (int i = 0; i < NUM_RELAYS; i++) begin
      dwell_ok[i] = (now_ms - chg_stamp_r[i]) >= TIME_W'(RELAY_MIN_DWELL_MS);
    end
    for (int c = 0; c < NUM_COMP; c++) begin
      on_time_ok[c]  = (now_ms - on_stamp_r[c])  >= TIME_W'(COMP_MIN_ON_TIME_MS);
      off_time_ok[c] = (now_ms - off_stamp_r[c]) >= TIME_W'(COMP_MIN_OFF_TIME_MS);
      // stamps move even if the relay guard refuses
      start_take[c]  = cmd.on_req[c] && !relay_bits_r[c] && off_time_ok[c];
      // a start this step resets the on stamp, so a stop cannot follow
      stop_take[c]   = cmd.off_req[c] && !start_take[c] && relay_bits_r[c] && on_time_ok[c];
      change[c]      = (start_take[c] || stop_take[c]) && dwell_ok[c];
    end
    for (int i = NUM_COMP; i < NUM_RELAYS; i++) begin
      change[i] = dwell_ok[i] && (relay_bits_r[i] ? cmd.off_req[i] : cmd.on_req[i]);
    end
    relay_bits_nxt = relay_bits_r ^ change;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relay_bits_r <= '0;
      for (int i = 0; i < NUM_RELAYS; i++) begin
        chg_stamp_r[i] <= '0;
      end
      for (int c = 0; c < NUM_COMP; c++) begin
        on_stamp_r[c]  <= '0;
        off_stamp_r[c] <= '0;
      end
    end else if (step) begin
      relay_bits_r <= relay_bits_nxt;
      for (int i = 0; i < NUM_RELAYS; i++) begin
        if (change[i]) begin
          chg_stamp_r[i] <= now_ms;
        end
      end
      for (int c = 0; c < NUM_COMP; c++) begin
        if (start_take[c]) begin
          on_stamp_r[c] <= now_ms;
        end
        if (stop_take[c]) begin
          off_stamp_r[c] <= now_ms;
        end
      end
    end
  end

  assign relay_bits = relay_bits_r;

endmodule

[rtl/core/cold_room_relay_sequencer.sv]
// ----------------------------------------------------------------------------
// cold_room_relay_sequencer
// Eight-relay cold room controller: fans, two-stage cooling, dehumidify,
// staged heating with failover and staged humidification, with dwell guards.
// ----------------------------------------------------------------------------
// Path: an input transaction is captured in s1, then its result is loaded into
//   the output register, which drives out_tvalid; a stalled output holds s1.
// Throughput: one evaluation per cycle while out_tready keeps the output free;
//   the relay/stamp update loops from the state registers through the command logic.
// Reset (rst_n low, synchronous): relays off, all stamps zero, registers back
//   to their defaults, both pipeline stages empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
module cold_room_relay_sequencer
  import crrs_pkg::*;
#(
  parameter int unsigned RELAY_MIN_DWELL_MS   = 30000,
  parameter int unsigned COMP_MIN_ON_TIME_MS  = 180000,
  parameter int unsigned COMP_MIN_OFF_TIME_MS = 180000
) (
  input  logic        clk,
  input  logic        rst_n,
  // evaluation input
  input  logic        in_tvalid,
  output logic        in_tready,
  // [31:0] now_ms, [43:32] temperature, [53:44] humidity,
  // [56:54] comp_one_faults, [59:57] comp_two_faults, [61:60] heater_faults
  input  logic [63:0] in_tdata,
  // relay result
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] relay_state
  output logic [7:0]  out_tdata,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  // register map
  localparam logic [2:0] CFG_TEMP_SP    = 3'd0;
  localparam logic [2:0] CFG_HUM_SP     = 3'd1;
  localparam logic [2:0] CFG_COOL_ON    = 3'd2;
  localparam logic [2:0] CFG_COOL_OFF   = 3'd3;
  localparam logic [2:0] CFG_COOL_STG2  = 3'd4;
  localparam logic [2:0] CFG_HUM_DBAND  = 3'd5;
  localparam logic [2:0] CFG_HUM_STG2   = 3'd6;

  cfg_t                  cfg_r;
  item_t                 s1_item_r;
  logic                  s1_valid_r;
  logic                  out_valid_r;
  logic [NUM_RELAYS-1:0] out_data_r;

  item_t                 in_item;
  relay_cmd_t            cmd;
  logic [NUM_RELAYS-1:0] relay_bits;
  logic [NUM_RELAYS-1:0] relay_bits_nxt;
  logic                  advance;

  // --------------------------------------------------------------------------
  // Register writes: the user writes only while idle, which the block does not enforce; always ready.
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.temp_setpoint     <= 12'sd40;
      cfg_r.hum_setpoint      <= 10'd850;
      cfg_r.cool_on_delta     <= 9'd10;
      cfg_r.cool_off_delta    <= 9'd10;
      cfg_r.cool_stage2_delta <= 9'd50;
      cfg_r.hum_deadband      <= 9'd20;
      cfg_r.hum_stage2_delta  <= 10'd100;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TEMP_SP:   cfg_r.temp_setpoint     <= signed'(cfg_data[11:0]);
        CFG_HUM_SP:    cfg_r.hum_setpoint      <= cfg_data[9:0];
        CFG_COOL_ON:   cfg_r.cool_on_delta     <= cfg_data[8:0];
        CFG_COOL_OFF:  cfg_r.cool_off_delta    <= cfg_data[8:0];
        CFG_COOL_STG2: cfg_r.cool_stage2_delta <= cfg_data[8:0];
        CFG_HUM_DBAND: cfg_r.hum_deadband      <= cfg_data[8:0];
        CFG_HUM_STG2:  cfg_r.hum_stage2_delta  <= cfg_data[9:0];
        default: ; // unmapped index: ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input stage. The evaluation is done from s1 straight into the output
  // register and the relay state, so s1 frees up whenever the output
  // register can take a new transaction.
  // --------------------------------------------------------------------------
  always_comb begin
    in_item.now_ms          = in_tdata[31:0];
    in_item.temperature     = signed'(in_tdata[43:32]);
    in_item.humidity        = in_tdata[53:44];
    in_item.comp_one_faults = in_tdata[56:54];
    in_item.comp_two_faults = in_tdata[59:57];
    in_item.heater_faults   = in_tdata[61:60];
  end

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r <= in_item;
    end
  end

  // --------------------------------------------------------------------------
  // Command generation and relay state
  // --------------------------------------------------------------------------
  crrs_cmd u_cmd (
    .item (s1_item_r),
    .cfg  (cfg_r),
    .cmd  (cmd)
  );

  crrs_relay_bank #(
    .RELAY_MIN_DWELL_MS   (RELAY_MIN_DWELL_MS),
    .COMP_MIN_ON_TIME_MS  (COMP_MIN_ON_TIME_MS),
    .COMP_MIN_OFF_TIME_MS (COMP_MIN_OFF_TIME_MS)
  ) u_bank (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (advance),
    .now_ms         (s1_item_r.now_ms),
    .cmd            (cmd),
    .relay_bits     (relay_bits),
    .relay_bits_nxt (relay_bits_nxt)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= relay_bits_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !s1_valid_r && !out_valid_r)
    else $error("pipeline not empty after reset");

  a_accept_loads : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> s1_valid_r)
    else $error("accepted transaction lost in input stage");

  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_tready |=> s1_valid_r && $stable(s1_item_r))
    else $error("input stage changed while output stalled");

  a_fans_stay_on : assert property (@(posedge clk) disable iff (!rst_n)
    $past(relay_bits[RLY_F1]) && $past(relay_bits[RLY_F2]) && $past(rst_n)
      |-> relay_bits[RLY_F1] && relay_bits[RLY_F2])
    else $error("fan relay switched off");

endmodule

[test/cold_room_relay_sequencer_tb.sv]
// ----------------------------------------------------------------------------
// cold_room_relay_sequencer_tb
// Self-checking bench for the relay sequencer. A behavioural predictor keeps
// its own relays, switch stamps and setpoints and works out the relay word for
// every accepted evaluation. Directed cases come first, then randomised runs
// over several register settings and handshake idling patterns.
// ----------------------------------------------------------------------------
module cold_room_relay_sequencer_tb;
  import crrs_pkg::*;

  localparam int unsigned DWELL_MS    = 30000;
  localparam int unsigned MIN_ON_MS   = 180000;
  localparam int unsigned MIN_OFF_MS  = 180000;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          LONG_HOLD   = 400;   // output hold-off, cycles

  // register map of the configuration channel
  typedef enum logic [2:0] {
    REG_TEMP_SP     = 3'd0,
    REG_HUM_SP      = 3'd1,
    REG_COOL_ON     = 3'd2,
    REG_COOL_OFF    = 3'd3,
    REG_COOL_STAGE2 = 3'd4,
    REG_HUM_DB      = 3'd5,
    REG_HUM_STAGE2  = 3'd6,
    REG_UNUSED      = 3'd7
  } reg_idx_t;

  // register settings a phase can run under
  typedef enum {SET_KEEP, SET_LOW, SET_HIGH, SET_WIDE, SET_TYPICAL} setting_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = '0;
  logic [11:0] cfg_data   = '0;

  cold_room_relay_sequencer #(
    .RELAY_MIN_DWELL_MS  (DWELL_MS),
    .COMP_MIN_ON_TIME_MS (MIN_ON_MS),
    .COMP_MIN_OFF_TIME_MS(MIN_OFF_MS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor state: relay word, per-relay switch stamps, compressor stamps
  // and the register copy. All start at their reset values.
  // --------------------------------------------------------------------------
  cfg_t        room_cfg = '{temp_setpoint: 12'sd40, hum_setpoint: 10'd850,
                            cool_on_delta: 9'd10, cool_off_delta: 9'd10,
                            cool_stage2_delta: 9'd50, hum_deadband: 9'd20,
                            hum_stage2_delta: 10'd100};
  logic [7:0]  relays = '0;
  logic [31:0] last_switch_ms  [NUM_RELAYS] = '{default: '0};
  logic [31:0] comp_started_ms [NUM_COMP]   = '{default: '0};
  logic [31:0] comp_stopped_ms [NUM_COMP]   = '{default: '0};
  logic [31:0] eval_ms = '0;

  // stimulus and scoreboard
  item_t       pending_evals [$];   // evaluations waiting to be offered
  logic [7:0]  relay_q [$];         // expected relay words, oldest first
  item_t       in_item;             // fields of the transaction on in_tdata
  logic [31:0] clock_ms = '0;       // running time base for random items
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  logic        recv_hold      = 1'b0;
  int          fail_count      = 0;
  int          evals_done      = 0;
  int          results_checked = 0;
  int          settings_loaded = 0;
  int          cycles          = 0;

  // Relay guard: only a real change that has waited out the dwell goes
  // through, and it restamps the relay, so a later reverse command in the
  // same evaluation is refused.
  function automatic void try_on(int r);
    if (!relays[r] && (eval_ms - last_switch_ms[r]) >= DWELL_MS) begin
      relays[r]         = 1'b1;
      last_switch_ms[r] = eval_ms;
    end
  endfunction

  function automatic void try_off(int r);
    if (relays[r] && (eval_ms - last_switch_ms[r]) >= DWELL_MS) begin
      relays[r]         = 1'b0;
      last_switch_ms[r] = eval_ms;
    end
  endfunction

  // compressor stamps move even when the relay guard refuses the change
  function automatic void try_comp_start(int c);
    if (!relays[c] && (eval_ms - comp_stopped_ms[c]) >= MIN_OFF_MS) begin
      try_on(c);
      comp_started_ms[c] = eval_ms;
    end
  endfunction

  function automatic void try_comp_stop(int c);
    if (relays[c] && (eval_ms - comp_started_ms[c]) >= MIN_ON_MS) begin
      try_off(c);
      comp_stopped_ms[c] = eval_ms;
    end
  endfunction

  // One control evaluation in the block's fixed command order.
  function automatic logic [7:0] next_relays(item_t e);
    int   t, h, sp_t, sp_h, on_d, off_d, st2_t, db_h, st2_h, err;
    logic c1_ok, c2_ok, ht1_ok, ht2_ok, need_cool, stop_cool, dehum, humid;
    t      = $signed(e.temperature);
    h      = e.humidity;
    sp_t   = $signed(room_cfg.temp_setpoint);
    sp_h   = room_cfg.hum_setpoint;
    on_d   = room_cfg.cool_on_delta;
    off_d  = room_cfg.cool_off_delta;
    st2_t  = room_cfg.cool_stage2_delta;
    db_h   = room_cfg.hum_deadband;
    st2_h  = room_cfg.hum_stage2_delta;
    c1_ok  = (e.comp_one_faults == 3'b000);
    c2_ok  = (e.comp_two_faults == 3'b000);
    ht1_ok = !e.heater_faults[0];
    ht2_ok = !e.heater_faults[1];
    eval_ms = e.now_ms;

    try_on(RLY_F1);
    try_on(RLY_F2);

    need_cool = t >= sp_t + on_d;
    stop_cool = t <= sp_t - off_d;
    dehum     = h > sp_h + db_h;
    humid     = !dehum && (h < sp_h - db_h);

    if (need_cool) begin
      try_off(RLY_T1);
      try_off(RLY_T2);
      if ((t - sp_t) > st2_t && c1_ok && c2_ok) begin
        try_comp_start(RLY_C1);
        try_comp_start(RLY_C2);
      end else if (c1_ok) begin
        try_comp_start(RLY_C1);
      end else if (c2_ok) begin
        try_comp_start(RLY_C2);
      end
    end

    // dehumidify: run a compressor and balance it with one heater
    if (!need_cool && !stop_cool && dehum) begin
      if (c1_ok) try_comp_start(RLY_C1);
      else if (c2_ok) try_comp_start(RLY_C2);
      if (ht1_ok) begin
        try_on(RLY_T1);
        try_off(RLY_T2);
      end else if (ht2_ok) begin
        try_on(RLY_T2);
        try_off(RLY_T1);
      end
    end

    if (stop_cool) begin
      try_comp_stop(RLY_C1);
      try_comp_stop(RLY_C2);
    end

    err = sp_t - t;
    if (err < HEAT_STAGE1_TENTHS) begin
      try_off(RLY_T1);
      try_off(RLY_T2);
    end else if (err < HEAT_STAGE2_TENTHS) begin
      if (ht1_ok) begin
        try_on(RLY_T1);
        try_off(RLY_T2);
      end else if (ht2_ok) begin
        try_on(RLY_T2);
        try_off(RLY_T1);
      end
    end else if (ht1_ok && ht2_ok) begin
      try_on(RLY_T1);
      try_on(RLY_T2);
    end

    if (humid) begin
      try_on(RLY_H1);
      if ((sp_h - h) > st2_h) try_on(RLY_H2);
      else try_off(RLY_H2);
    end else begin
      try_off(RLY_H1);
      try_off(RLY_H2);
    end
    return relays;
  endfunction

  // --------------------------------------------------------------------------
  // Input driver. A transaction completes on an edge with tvalid and tready
  // high; its expected relay word is worked out at that edge. A new item is
  // then offered or tvalid drops, one assignment per edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : eval_driver
    item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        relay_q.push_back(next_relays(in_item));
        evals_done++;
      end
      if (pending_evals.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        nxt = pending_evals.pop_front();
        in_item   <= nxt;
        in_tdata  <= {2'b00, nxt.heater_faults, nxt.comp_two_faults,
                      nxt.comp_one_faults, nxt.humidity, nxt.temperature,
                      nxt.now_ms};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: every output transaction is matched with the oldest
  // expected relay word. tready is randomised, or held low during a hold-off.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : relay_monitor
    logic [7:0] want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (relay_q.size() == 0) begin
          $error("relay_state: unexpected result %08b", out_tdata);
          fail_count++;
        end else begin
          want = relay_q.pop_front();
          results_checked++;
          if (out_tdata !== want) begin
            $error("relay_state mismatch: expected %08b, actual %08b", want, out_tdata);
            fail_count++;
          end
        end
      end
      out_tready <= !recv_hold && ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $error("timed out with %0d results outstanding", relay_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic write_setting(reg_idx_t idx, logic [11:0] raw);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= raw;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    // register taken at its own width; the spare index is dropped
    case (idx)
      REG_TEMP_SP:     room_cfg.temp_setpoint     = raw[11:0];
      REG_HUM_SP:      room_cfg.hum_setpoint      = raw[9:0];
      REG_COOL_ON:     room_cfg.cool_on_delta     = raw[8:0];
      REG_COOL_OFF:    room_cfg.cool_off_delta    = raw[8:0];
      REG_COOL_STAGE2: room_cfg.cool_stage2_delta = raw[8:0];
      REG_HUM_DB:      room_cfg.hum_deadband      = raw[8:0];
      REG_HUM_STAGE2:  room_cfg.hum_stage2_delta  = raw[9:0];
      default: ;
    endcase
  endtask

  // full register load; with junk set the unused upper data bits are random
  task automatic load_room_cfg(cfg_t c, bit junk);
    logic [11:0] pad;
    pad = junk ? 12'($urandom) : 12'h000;
    write_setting(REG_TEMP_SP,     c.temp_setpoint);
    write_setting(REG_HUM_SP,      {pad[11:10], c.hum_setpoint});
    write_setting(REG_COOL_ON,     {pad[11:9], c.cool_on_delta});
    write_setting(REG_COOL_OFF,    {pad[11:9], c.cool_off_delta});
    write_setting(REG_COOL_STAGE2, {pad[11:9], c.cool_stage2_delta});
    write_setting(REG_HUM_DB,      {pad[11:9], c.hum_deadband});
    write_setting(REG_HUM_STAGE2,  {pad[11:10], c.hum_stage2_delta});
    if (junk) write_setting(REG_UNUSED, 12'($urandom));
    settings_loaded++;
  endtask

  function automatic cfg_t pick_setting(setting_t kind);
    cfg_t c;
    int   sp;
    case (kind)
      SET_LOW: c = '{temp_setpoint: -12'sd500, hum_setpoint: 10'd0,
                     cool_on_delta: 9'd0, cool_off_delta: 9'd0,
                     cool_stage2_delta: 9'd0, hum_deadband: 9'd0,
                     hum_stage2_delta: 10'd0};
      SET_HIGH: c = '{temp_setpoint: 12'sd1500, hum_setpoint: 10'd1000,
                      cool_on_delta: 9'd500, cool_off_delta: 9'd500,
                      cool_stage2_delta: 9'd500, hum_deadband: 9'd500,
                      hum_stage2_delta: 10'd1000};
      SET_WIDE: begin
        // anything the register widths allow, in range or not
        c.temp_setpoint     = 12'($urandom);
        c.hum_setpoint      = 10'($urandom);
        c.cool_on_delta     = 9'($urandom);
        c.cool_off_delta    = 9'($urandom);
        c.cool_stage2_delta = 9'($urandom);
        c.hum_deadband      = 9'($urandom);
        c.hum_stage2_delta  = 10'($urandom);
      end
      default: begin
        sp = $urandom_range(140, 0);
        sp = sp - 40;
        c.temp_setpoint     = sp[11:0];
        c.hum_setpoint      = 10'($urandom_range(950, 600));
        c.cool_on_delta     = 9'($urandom_range(40, 0));
        c.cool_off_delta    = 9'($urandom_range(40, 0));
        c.cool_stage2_delta = 9'($urandom_range(120, 0));
        c.hum_deadband      = 9'($urandom_range(60, 0));
        c.hum_stage2_delta  = 10'($urandom_range(200, 0));
      end
    endcase
    return c;
  endfunction

  task automatic queue_eval(logic [31:0] ms, int temp, int hum,
                            logic [2:0] f1, logic [2:0] f2, logic [1:0] hf);
    item_t e;
    e.now_ms          = ms;
    e.temperature     = temp[11:0];
    e.humidity        = hum[9:0];
    e.comp_one_faults = f1;
    e.comp_two_faults = f2;
    e.heater_faults   = hf;
    pending_evals.push_back(e);
  endtask

  // Random evaluations around the current setpoints. Time mostly moves in
  // steps near the dwell and compressor windows, now and then it jumps,
  // which also carries it across the 32-bit wrap.
  task automatic queue_random_evals(int n);
    int sel, off, tv, hv;
    logic [2:0] f1, f2;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99, 0);
      if (sel < 8)       clock_ms += 32'($urandom_range(2000, 0));
      else if (sel < 68) clock_ms += 32'($urandom_range(45000, 0));
      else if (sel < 97) clock_ms += 32'($urandom_range(250000, 45000));
      else               clock_ms = $urandom;

      sel = $urandom_range(99, 0);
      off = $urandom_range(300, 0);
      if (sel < 80)      tv = $signed(room_cfg.temp_setpoint) + off - 150;
      else if (sel < 90) tv = $urandom_range(2000, 0) - 500;
      else               tv = $urandom;

      sel = $urandom_range(99, 0);
      off = $urandom_range(400, 0);
      if (sel < 80) hv = room_cfg.hum_setpoint + off - 250;
      else          hv = $urandom;

      // healthy plant most of the time
      f1 = ($urandom_range(99, 0) < 75) ? 3'b000 : 3'($urandom);
      f2 = ($urandom_range(99, 0) < 75) ? 3'b000 : 3'($urandom);
      queue_eval(clock_ms, tv, hv, f1, f2,
                 ($urandom_range(99, 0) < 70) ? 2'b00 : 2'($urandom));
    end
  endtask

  // sender stays quiet until every expected relay word has come back
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_evals.size() != 0 || in_tvalid || relay_q.size() != 0);
  endtask

  task automatic run_phase(setting_t kind, int send_pct, int recv_pct, int n,
                           bit long_hold);
    if (kind != SET_KEEP) load_room_cfg(pick_setting(kind), kind == SET_WIDE);
    send_idle_pct  <= send_pct;
    recv_stall_pct <= recv_pct;
    if (long_hold) begin
      // output held off while items keep coming: the block fills up and
      // must stall its input; the hold is timed by its own process
      recv_hold <= 1'b1;
      fork
        begin
          repeat (LONG_HOLD) @(posedge clk);
          recv_hold <= 1'b0;
        end
      join_none
    end
    queue_random_evals(n);
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset setpoints (40 / 850).
    // just after reset every relay is still inside its dwell window
    queue_eval(32'd0,       40,  850, 3'b000, 3'b000, 2'b00);
    queue_eval(32'd29999,  200,  950, 3'b000, 3'b000, 2'b00);
    // fans come on; compressors still held by the minimum off time
    queue_eval(32'd30000,  200,  950, 3'b000, 3'b000, 2'b00);
    // far above setpoint: second compressor stage
    queue_eval(32'd180000, 200,  950, 3'b000, 3'b000, 2'b00);
    // stop asked inside the minimum on time; heavy heating demand, dry room
    queue_eval(32'd250000, -100, 500, 3'b000, 3'b000, 2'b00);
    // minimum on time met, compressors drop
    queue_eval(32'd400000, -100, 500, 3'b000, 3'b000, 2'b00);
    // heating stage one with heater 1 tripped fails over to heater 2
    queue_eval(32'd450000, -10,  840, 3'b000, 3'b000, 2'b01);
    // stage one, both healthy; humidity shortfall just over stage two
    queue_eval(32'd500000, -10,  749, 3'b000, 3'b000, 2'b00);
    // stage two heating with a heater fault leaves the heaters alone;
    // shortfall exactly at the stage two delta
    queue_eval(32'd540000, -100, 750, 3'b000, 3'b000, 2'b10);
    queue_eval(32'd580000, 0,    830, 3'b000, 3'b000, 2'b00);
    // in the band but damp, compressor 1 tripped: dehumidify on compressor 2;
    // the heater just switched on may not be reversed in the same step
    queue_eval(32'd800000, 45,   900, 3'b111, 3'b000, 2'b00);
    // cooling exactly at the on threshold, compressor 1 faulty
    queue_eval(32'd1000000, 50,  850, 3'b001, 3'b000, 2'b00);
    // above stage two with compressor 2 faulty: one stage only
    queue_eval(32'd1300000, 100, 850, 3'b000, 3'b010, 2'b00);
    // exactly at the off threshold
    queue_eval(32'd1600000, 30,  850, 3'b000, 3'b000, 2'b00);
    // field extremes and time crossing the wrap
    queue_eval(32'hFFFF_FFF0, -2048, 1023, 3'b111, 3'b111, 2'b11);
    queue_eval(32'h0000_7000, 2047,  0,    3'b100, 3'b100, 2'b00);
    queue_eval(32'h8000_0000, 1500,  1000, 3'b000, 3'b000, 2'b00);
    queue_eval(32'h8010_0000, -500,  0,    3'b000, 3'b000, 2'b00);
    // dead band, then rapid evaluations inside the dwell
    queue_eval(32'h8020_0000, 40,    850,  3'b000, 3'b000, 2'b00);
    queue_eval(32'h8020_0001, 40,    827,  3'b000, 3'b000, 2'b00);
    queue_eval(32'h8030_0000, 40,    828,  3'b000, 3'b000, 2'b00);
    clock_ms = 32'h8030_0000;
    wait_drained();

    // Randomised phases: setting, sender idle %, receiver stall %, items
    run_phase(SET_KEEP,    0,  0,  110, 1'b0);
    run_phase(SET_LOW,     46, 0,  110, 1'b0);
    run_phase(SET_HIGH,    0,  46, 110, 1'b0);
    run_phase(SET_WIDE,    16, 16, 110, 1'b0);
    run_phase(SET_TYPICAL, 0,  0,  120, 1'b1);
    run_phase(SET_TYPICAL, 46, 0,  110, 1'b0);
    run_phase(SET_TYPICAL, 0,  46, 110, 1'b0);
    run_phase(SET_TYPICAL, 16, 16, 110, 1'b0);

    // let anything stray surface from the s1 and output registers
    repeat (10) @(posedge clk);
    if (relay_q.size() != 0) begin
      $error("relay_state: %0d expected results never arrived", relay_q.size());
      fail_count++;
    end

    $display("Checked %0d relay words from %0d evaluations over %0d register loads.",
             results_checked, evals_done, settings_loaded);
    $display("Covered dwell and compressor timing, wrapping time, faults, gaps, stalls and back-pressure.");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
